[rtl/threshold_network_attractor_search_assert.svh]
// Assertion macros for the threshold network attractor search block.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef THRESHOLD_NETWORK_ATTRACTOR_SEARCH_ASSERT_SVH
`define THRESHOLD_NETWORK_ATTRACTOR_SEARCH_ASSERT_SVH

// Check a property at every clock edge outside reset.
`define TNA_CHECK(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Check a property at every clock edge, reset included.
`define TNA_CHECK_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

[rtl/tna_pkg.sv]
// Shared types and constants of the threshold network attractor search block.
// No dependencies.
`timescale 1ns / 1ps

package tna_pkg;

   localparam int STATE_W     = 8;
   localparam int STEP_W      = 10;
   localparam int CYC_W       = 5;
   localparam int MASK_W      = 64;
   localparam int MASK_STRIDE = 8;
   localparam int CSR_IDX_W   = 2;

   localparam logic [STEP_W-1:0] MAX_UPDATES_RST = 10'd100;
   localparam logic [CYC_W-1:0]  MAX_CYCLE_RST   = 5'd16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PLUS_EDGE_MASK  = 2'd0,
      CSR_MINUS_EDGE_MASK = 2'd1,
      CSR_MAX_UPDATES     = 2'd2,
      CSR_MAX_CYCLE       = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } fsm_type;

   // Outcome of the history compare: hit and the shortest matching cycle.
   typedef struct packed {
      logic             hit;
      logic [CYC_W-1:0] len;
   } match_type;

endpackage

[rtl/threshold_network_attractor_search.sv]
// Threshold network attractor search: takes an initial state of GENES binary genes per
// request word, steps a synchronous +1/-1 threshold network built from the plus and minus
// edge masks, and returns one response word when a state repeats within cyc-1 steps
// (cyc is max_cycle capped at HISTORY_DEPTH) or the step count reaches max_updates. One
// request is worked on at a time: after the accept cycle the block computes one network
// step per clock. When a word is produced the block returns to idle and takes the next
// request from there. A finished word sits in the response register and a new request
// is taken while it waits. The next search freezes at its last step only if that
// register is still stalled. Configuration must be written between searches; the block
// itself does not enforce this.
`timescale 1ns / 1ps
`include "threshold_network_attractor_search_assert.svh"

module threshold_network_attractor_search #(
   parameter int GENES         = 8,
   parameter int HISTORY_DEPTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   // configuration write port
   input  logic                            csr_write_enable,
   input  logic [tna_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tna_pkg::MASK_W-1:0]      csr_write_data,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [tna_pkg::STATE_W-1:0]     req_start_state,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [tna_pkg::STATE_W-1:0]     rsp_end_state,
   output logic [tna_pkg::STEP_W-1:0]      rsp_step_count,
   output logic                            rsp_settled,
   output logic [tna_pkg::CYC_W-1:0]       rsp_cycle_length
);

   // ---------------------------------------------------------------- config
   logic [tna_pkg::MASK_W-1:0] plus_mask_ff;
   logic [tna_pkg::MASK_W-1:0] minus_mask_ff;
   logic [tna_pkg::STEP_W-1:0] max_updates_ff;
   logic [tna_pkg::CYC_W-1:0]  max_cycle_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         plus_mask_ff   <= '0;
         minus_mask_ff  <= '0;
         max_updates_ff <= tna_pkg::MAX_UPDATES_RST;
         max_cycle_ff   <= tna_pkg::MAX_CYCLE_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            tna_pkg::CSR_PLUS_EDGE_MASK:  plus_mask_ff   <= csr_write_data;
            tna_pkg::CSR_MINUS_EDGE_MASK: minus_mask_ff  <= csr_write_data;
            tna_pkg::CSR_MAX_UPDATES:     max_updates_ff <= csr_write_data[tna_pkg::STEP_W-1:0];
            tna_pkg::CSR_MAX_CYCLE:       max_cycle_ff   <= csr_write_data[tna_pkg::CYC_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective limits: zero acts as one, cycle limit saturates to the history depth.
   logic [tna_pkg::STEP_W-1:0] limit;
   logic [tna_pkg::CYC_W-1:0]  cyc_floor;
   logic [tna_pkg::CYC_W-1:0]  cyc;

   assign limit     = (max_updates_ff == '0) ? tna_pkg::STEP_W'(1) : max_updates_ff;
   assign cyc_floor = (max_cycle_ff == '0) ? tna_pkg::CYC_W'(1) : max_cycle_ff;
   assign cyc       = ({2'b00, cyc_floor} > 7'(HISTORY_DEPTH))
                    ? tna_pkg::CYC_W'(HISTORY_DEPTH) : cyc_floor;

   // ---------------------------------------------------------------- state
   tna_pkg::fsm_type                    state_ff, state_in;
   logic [tna_pkg::STEP_W-1:0]          t_ff, t_in;
   // hist_ff[0] is the current state, hist_ff[j] the state j steps before it.
   logic [HISTORY_DEPTH-2:0][GENES-1:0] hist_ff, hist_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [tna_pkg::STATE_W-1:0]         rsp_end_state_ff, rsp_end_state_in;
   logic [tna_pkg::STEP_W-1:0]          rsp_step_count_ff, rsp_step_count_in;
   logic                                rsp_settled_ff, rsp_settled_in;
   logic [tna_pkg::CYC_W-1:0]           rsp_cycle_length_ff, rsp_cycle_length_in;

   // ---------------------------------------------------------------- gene lanes
   logic [GENES-1:0] nxt;

   for (genvar tgt = 0; tgt < GENES; tgt++) begin : g_lane
      logic [GENES-1:0] plus_col;
      logic [GENES-1:0] minus_col;

      // Column of the masks that feeds this target gene.
      for (genvar src = 0; src < GENES; src++) begin : g_col
         assign plus_col[src]  = plus_mask_ff[src * tna_pkg::MASK_STRIDE + tgt];
         assign minus_col[src] = minus_mask_ff[src * tna_pkg::MASK_STRIDE + tgt];
      end

      tna_lane #(
         .GENES     (GENES)
      ) u_lane (
         .src_state (hist_ff[0]),
         .plus_col  (plus_col),
         .minus_col (minus_col),
         .next_bit  (nxt[tgt])
      );
   end

   // ---------------------------------------------------------------- history compare
   tna_pkg::match_type match;

   tna_match #(
      .GENES         (GENES),
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_match (
      .cand   (nxt),
      .hist   (hist_ff),
      .step   (t_ff),
      .cyc    (cyc),
      .result (match)
   );

   // ---------------------------------------------------------------- control
   logic slot_free;

   // The response register can take a word this cycle.
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in            = state_ff;
      t_in                = t_ff;
      hist_in             = hist_ff;
      rsp_valid_in        = rsp_valid_ff && rsp_stall;
      rsp_end_state_in    = rsp_end_state_ff;
      rsp_step_count_in   = rsp_step_count_ff;
      rsp_settled_in      = rsp_settled_ff;
      rsp_cycle_length_in = rsp_cycle_length_ff;

      case (state_ff)
         tna_pkg::ST_IDLE: begin
            // Load the start state as step zero; bits above GENES drop out.
            if (req_valid) begin
               hist_in[0] = req_start_state[GENES-1:0];
               t_in       = tna_pkg::STEP_W'(1);
               state_in   = tna_pkg::ST_RUN;
            end
         end
         tna_pkg::ST_RUN: begin
            if (t_ff >= limit) begin
               // Limit reached without a repeat: report the last state once the
               // previous word has left; hold here otherwise.
               if (slot_free) begin
                  rsp_valid_in        = 1'b1;
                  rsp_end_state_in    = tna_pkg::STATE_W'(hist_ff[0]);
                  rsp_step_count_in   = t_ff;
                  rsp_settled_in      = 1'b0;
                  rsp_cycle_length_in = cyc;
                  state_in            = tna_pkg::ST_IDLE;
               end
            end else if (match.hit) begin
               // Repeat found: hold this step until the output register is free.
               if (slot_free) begin
                  rsp_valid_in        = 1'b1;
                  rsp_end_state_in    = tna_pkg::STATE_W'(nxt);
                  rsp_step_count_in   = t_ff;
                  rsp_settled_in      = 1'b1;
                  rsp_cycle_length_in = match.len;
                  state_in            = tna_pkg::ST_IDLE;
               end
            end else begin
               // Advance one step: shift the history and push the new state.
               hist_in[0] = nxt;
               for (int j = 1; j < HISTORY_DEPTH - 1; j++) begin
                  hist_in[j] = hist_ff[j-1];
               end
               t_in = t_ff + tna_pkg::STEP_W'(1);
            end
         end
         default: begin
            state_in = tna_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tna_pkg::ST_IDLE;
         t_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         t_ff         <= t_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hist_ff             <= hist_in;
      rsp_end_state_ff    <= rsp_end_state_in;
      rsp_step_count_ff   <= rsp_step_count_in;
      rsp_settled_ff      <= rsp_settled_in;
      rsp_cycle_length_ff <= rsp_cycle_length_in;
   end

   // ---------------------------------------------------------------- outputs
   assign req_stall        = (state_ff != tna_pkg::ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_end_state    = rsp_end_state_ff;
   assign rsp_step_count   = rsp_step_count_ff;
   assign rsp_settled      = rsp_settled_ff;
   assign rsp_cycle_length = rsp_cycle_length_ff;

   // ---------------------------------------------------------------- assertions
   logic in_run;
   logic rsp_unsettled;
   logic rsp_settled_word;
   logic len_ok;

   assign in_run           = (state_ff == tna_pkg::ST_RUN);
   assign rsp_unsettled    = rsp_valid_ff && !rsp_settled_ff;
   assign rsp_settled_word = rsp_valid_ff && rsp_settled_ff;
   assign len_ok           = (rsp_cycle_length_ff != '0) && (rsp_cycle_length_ff < cyc)
                          && ({5'b00000, rsp_cycle_length_ff} <= rsp_step_count_ff);

   `TNA_CHECK(a_step_in_range, in_run |-> (t_ff <= limit), "step counter past limit")
   `TNA_CHECK(a_unsettled_at_limit, rsp_unsettled |-> (rsp_step_count_ff == limit), "bad step")
   `TNA_CHECK(a_settled_len, rsp_settled_word |-> len_ok, "settled word with bad cycle length")
   `TNA_CHECK(a_word_from_run, $rose(rsp_valid_ff) |-> $past(in_run), "word without a search")
   `TNA_CHECK_ALWAYS(a_reset_clears, $past(reset) |-> (!rsp_valid_ff && !req_stall), "busy")

endmodule

[rtl/tna_lane.sv]
// One gene lane: threshold update of a single target gene.
// Depends on nothing but its parameter.
`timescale 1ns / 1ps

module tna_lane #(
   parameter int GENES = 8
) (
   input  logic [GENES-1:0] src_state,
   input  logic [GENES-1:0] plus_col,
   input  logic [GENES-1:0] minus_col,
   output logic             next_bit
);

   localparam int CNT_W = $clog2(GENES + 1);

   logic [GENES-1:0] up;
   logic [GENES-1:0] down;
   logic [CNT_W-1:0] up_cnt;
   logic [CNT_W-1:0] down_cnt;

   // Cancelled edges (both bits set) contribute nothing.
   assign up   = (plus_col & ~minus_col & src_state) | (minus_col & ~plus_col & ~src_state);
   assign down = (plus_col & ~minus_col & ~src_state) | (minus_col & ~plus_col & src_state);

   always_comb begin
      up_cnt   = '0;
      down_cnt = '0;
      for (int s = 0; s < GENES; s++) begin
         up_cnt   = up_cnt + CNT_W'(up[s]);
         down_cnt = down_cnt + CNT_W'(down[s]);
      end
   end

   // Sum above zero means more positive than negative terms.
   assign next_bit = (up_cnt > down_cnt);

endmodule

[rtl/tna_match.sv]
// History compare lanes and merge: finds the shortest cycle ending in the new state.
// Depends on tna_pkg.
`timescale 1ns / 1ps

module tna_match #(
   parameter int GENES         = 8,
   parameter int HISTORY_DEPTH = 16
) (
   input  logic [GENES-1:0]                       cand,
   input  logic [HISTORY_DEPTH-2:0][GENES-1:0]    hist,
   input  logic [tna_pkg::STEP_W-1:0]             step,
   input  logic [tna_pkg::CYC_W-1:0]              cyc,
   output tna_pkg::match_type                     result
);

   logic [HISTORY_DEPTH-2:0]   hit;
   logic [tna_pkg::STEP_W-1:0] cyc_ext;

   assign cyc_ext = {{(tna_pkg::STEP_W - tna_pkg::CYC_W){1'b0}}, cyc};

   // Entry j holds the state j+1 steps back; it counts once written and in range.
   always_comb begin
      for (int j = 0; j < HISTORY_DEPTH - 1; j++) begin
         hit[j] = (hist[j] == cand)
               && (tna_pkg::STEP_W'(j + 1) <= step)
               && (tna_pkg::STEP_W'(j + 1) < cyc_ext);
      end
   end

   // Merge: the shortest matching distance wins.
   always_comb begin
      result = '0;
      for (int j = HISTORY_DEPTH - 2; j >= 0; j--) begin
         if (hit[j]) begin
            result.hit = 1'b1;
            result.len = tna_pkg::CYC_W'(j + 1);
         end
      end
   end

endmodule

[bench/testbench.sv]
// Self-checking bench for the threshold network attractor search block.
// Depends on tna_pkg and the block's top level; holds its own attractor predictor.
`timescale 1ns / 1ps

module testbench;

   localparam int HIST_DEPTH  = 16;
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int TAIL_CYCLES = 1100;
   localparam int RAND_PHASES = 16;
   localparam int PHASE_WORDS = 36;

   localparam logic [tna_pkg::MASK_W-1:0] DIAG_MASK   = 64'h8040_2010_0804_0201;
   localparam logic [tna_pkg::MASK_W-1:0] ROTATE_MASK = 64'h0180_4020_1008_0402;
   localparam logic [tna_pkg::MASK_W-1:0] ALL_ONES    = '1;

   // Expected outcome of one search, in the order the response word carries it.
   typedef struct packed {
      logic [tna_pkg::STATE_W-1:0] end_state;
      logic [tna_pkg::STEP_W-1:0]  step_count;
      logic                        settled;
      logic [tna_pkg::CYC_W-1:0]   cycle_length;
   } attractor_type;

   // Mirror of the register file plus the queue of searches still owed by the block.
   class attractor_scoreboard_type;
      logic [tna_pkg::MASK_W-1:0] plus_mask;
      logic [tna_pkg::MASK_W-1:0] minus_mask;
      logic [tna_pkg::STEP_W-1:0] update_limit;
      logic [tna_pkg::CYC_W-1:0]  cycle_limit;
      attractor_type              owed_q[$];
      int unsigned                failures;

      function new();
         plus_mask    = '0;
         minus_mask   = '0;
         update_limit = tna_pkg::MAX_UPDATES_RST;
         cycle_limit  = tna_pkg::MAX_CYCLE_RST;
         failures     = 0;
      endfunction

      function void write_reg(tna_pkg::csr_index_type idx, logic [tna_pkg::MASK_W-1:0] data);
         case (idx)
            tna_pkg::CSR_PLUS_EDGE_MASK:  plus_mask    = data;
            tna_pkg::CSR_MINUS_EDGE_MASK: minus_mask   = data;
            tna_pkg::CSR_MAX_UPDATES:     update_limit = data[tna_pkg::STEP_W-1:0];
            tna_pkg::CSR_MAX_CYCLE:       cycle_limit  = data[tna_pkg::CYC_W-1:0];
            default: ;
         endcase
      endfunction

      // One synchronous network step: each target takes the sign of its weighted sum.
      function logic [tna_pkg::STATE_W-1:0] next_genes(logic [tna_pkg::STATE_W-1:0] cur);
         logic [tna_pkg::STATE_W-1:0] nxt;
         int sum;
         int w;
         int v;
         nxt = '0;
         for (int tgt = 0; tgt < tna_pkg::STATE_W; tgt++) begin
            sum = 0;
            for (int src = 0; src < tna_pkg::STATE_W; src++) begin
               w = int'(plus_mask[src*tna_pkg::MASK_STRIDE+tgt])
                 - int'(minus_mask[src*tna_pkg::MASK_STRIDE+tgt]);
               v = cur[src] ? 1 : -1;
               sum += w * v;
            end
            nxt[tgt] = (sum > 0);
         end
         return nxt;
      endfunction

      // Run the whole search for one start word and queue its outcome.
      function void note_request(logic [tna_pkg::STATE_W-1:0] start);
         logic [tna_pkg::STATE_W-1:0] hist [HIST_DEPTH];
         logic [tna_pkg::STATE_W-1:0] cur;
         int unsigned                 step_lim;
         int unsigned                 cyc;
         int unsigned                 cl;
         int unsigned                 t;
         bit                          hit;
         attractor_type               res;
         step_lim = (update_limit == 0) ? 1 : update_limit;
         cyc      = (cycle_limit == 0) ? 1 : cycle_limit;
         if (cyc > HIST_DEPTH)
            cyc = HIST_DEPTH;
         cl      = cyc;
         cur     = start;
         hist[0] = cur;
         t       = 1;
         hit     = 1'b0;
         while (!hit && t < step_lim) begin
            cur = next_genes(cur);
            hist[t % HIST_DEPTH] = cur;
            // only entries written during this search are ever compared
            for (int unsigned c = 1; c < cyc && !hit; c++) begin
               if (t >= c && hist[(t - c) % HIST_DEPTH] == cur) begin
                  hit = 1'b1;
                  cl  = c;
               end
            end
            if (!hit)
               t++;
         end
         res.end_state    = cur;
         res.step_count   = t[tna_pkg::STEP_W-1:0];
         res.settled      = hit;
         res.cycle_length = cl[tna_pkg::CYC_W-1:0];
         owed_q.push_back(res);
      endfunction

      function void check_response(logic [tna_pkg::STATE_W-1:0] end_state,
                                   logic [tna_pkg::STEP_W-1:0] step_count,
                                   logic settled,
                                   logic [tna_pkg::CYC_W-1:0] cycle_length);
         attractor_type exp_res;
         if (owed_q.size() == 0) begin
            $error("response word with no search outstanding: end_state %0h", end_state);
            failures++;
            return;
         end
         exp_res = owed_q.pop_front();
         if (end_state !== exp_res.end_state) begin
            $error("end_state expected %0h actual %0h", exp_res.end_state, end_state);
            failures++;
         end
         if (step_count !== exp_res.step_count) begin
            $error("step_count expected %0d actual %0d", exp_res.step_count, step_count);
            failures++;
         end
         if (settled !== exp_res.settled) begin
            $error("settled expected %0b actual %0b", exp_res.settled, settled);
            failures++;
         end
         if (cycle_length !== exp_res.cycle_length) begin
            $error("cycle_length expected %0d actual %0d", exp_res.cycle_length, cycle_length);
            failures++;
         end
      endfunction
   endclass

   logic                         clock            = 1'b0;
   logic                         reset            = 1'b1;
   logic                         csr_write_enable = 1'b0;
   tna_pkg::csr_index_type       csr_index        = tna_pkg::CSR_PLUS_EDGE_MASK;
   logic [tna_pkg::MASK_W-1:0]   csr_write_data   = '0;
   logic                         req_valid        = 1'b0;
   logic                         req_stall;
   logic [tna_pkg::STATE_W-1:0]  req_start_state  = '0;
   logic                         rsp_valid;
   logic                         rsp_stall        = 1'b0;
   logic [tna_pkg::STATE_W-1:0]  rsp_end_state;
   logic [tna_pkg::STEP_W-1:0]   rsp_step_count;
   logic                         rsp_settled;
   logic [tna_pkg::CYC_W-1:0]    rsp_cycle_length;

   attractor_scoreboard_type     sb;
   int unsigned                  words_sent    = 0;
   int unsigned                  cycle_count   = 0;
   int unsigned                  send_idle_pct = 25;
   int unsigned                  recv_idle_pct = 47;

   threshold_network_attractor_search u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_start_state  (req_start_state),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_end_state    (rsp_end_state),
      .rsp_step_count   (rsp_step_count),
      .rsp_settled      (rsp_settled),
      .rsp_cycle_length (rsp_cycle_length)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop: far beyond the slowest legal run, with every search at its step limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Receiver back-pressure; change only at the falling edge so the rising edge sees it stable.
   always @(negedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   // Compare every accepted response word against the oldest outstanding search.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_end_state, rsp_step_count, rsp_settled, rsp_cycle_length);
   end

   // Pick the idle profile from how far the stimulus has come: receiver-heavy gaps first,
   // then sender-heavy, then a stretch with no gaps at all.
   task automatic update_idle_profile();
      if (words_sent < 198) begin
         send_idle_pct = 25;
         recv_idle_pct = 47;
      end else if (words_sent < 396) begin
         send_idle_pct = 47;
         recv_idle_pct = 25;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   endtask

   // Offer one start word; hold it until the block takes it.
   task automatic send_word(logic [tna_pkg::STATE_W-1:0] start);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_start_state <= start;
      do @(posedge clock); while (req_stall);
      sb.note_request(start);
      words_sent++;
      update_idle_profile();
   endtask

   // Drop valid and wait until every outstanding search has answered.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.owed_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_csr(tna_pkg::csr_index_type idx, logic [tna_pkg::MASK_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      sb.write_reg(idx, data);
   endtask

   // Reprogram all four registers with the block idle.
   task automatic configure(logic [tna_pkg::MASK_W-1:0] plus_m,
                            logic [tna_pkg::MASK_W-1:0] minus_m,
                            logic [tna_pkg::MASK_W-1:0] upd_data,
                            logic [tna_pkg::MASK_W-1:0] cyc_data);
      drain();
      write_csr(tna_pkg::CSR_PLUS_EDGE_MASK, plus_m);
      write_csr(tna_pkg::CSR_MINUS_EDGE_MASK, minus_m);
      write_csr(tna_pkg::CSR_MAX_UPDATES, upd_data);
      write_csr(tna_pkg::CSR_MAX_CYCLE, cyc_data);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      logic [tna_pkg::MASK_W-1:0] plus_m;
      logic [tna_pkg::MASK_W-1:0] minus_m;
      logic [tna_pkg::MASK_W-1:0] upd_data;
      logic [tna_pkg::MASK_W-1:0] cyc_data;
      sb = new();

      // hold reset, then release it at a falling edge
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: no edges, so every gene falls to -1 and settles on a fixed point.
      send_word(8'h00);
      send_word(8'hFF);
      send_word(8'hA5);

      // Self loops only: every start state is already a fixed point.
      configure(DIAG_MASK, '0, 64'd1023, 64'd16);
      send_word(8'h00);
      send_word(8'hFF);
      send_word(8'h3C);

      // Self inverters give a length-two cycle: run to the limit checking length one only, then find it.
      configure('0, DIAG_MASK, 64'd1023, 64'd2);
      send_word(8'h5A);
      configure('0, DIAG_MASK, 64'd40, 64'd3);
      send_word(8'h0F);

      // Limit of one: no step taken, start word comes straight back.
      configure(ROTATE_MASK, '0, 64'd1, 64'd16);
      send_word(8'hC3);
      send_word(8'hFF);
      // Zero step limit behaves as one.
      configure(ROTATE_MASK, DIAG_MASK, 64'd0, 64'd16);
      send_word(8'h81);

      // Zero cycle limit: nothing checked, runs to the limit and reports length one.
      configure(DIAG_MASK, '0, 64'd5, 64'd0);
      send_word(8'h12);

      // Rotation ring with cycle limit beyond the history: saturate to the history depth.
      configure(ROTATE_MASK, '0, 64'd200, 64'd31);
      send_word(8'h01);
      send_word(8'h03);
      configure(ROTATE_MASK, '0, 64'd7, 64'd20);
      send_word(8'h01);

      // Both masks full: every edge cancels.
      configure(ALL_ONES, ALL_ONES, 64'd100, 64'd16);
      send_word(8'hFF);
      // Full plus mask: majority vote of all genes.
      configure(ALL_ONES, '0, 64'd100, 64'd1);
      send_word(8'hF8);
      send_word(8'h07);

      // Random phases: fresh network and limits per phase, random start words within.
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         case ($urandom_range(0, 3))
            0: begin
               plus_m  = {$urandom, $urandom};
               minus_m = {$urandom, $urandom};
            end
            1: begin
               plus_m  = {$urandom, $urandom} & {$urandom, $urandom};
               minus_m = {$urandom, $urandom} & {$urandom, $urandom};
            end
            2: begin
               plus_m  = {$urandom, $urandom};
               minus_m = ~plus_m & {$urandom, $urandom};
            end
            default: begin
               plus_m  = {$urandom, $urandom} & {$urandom, $urandom} | DIAG_MASK;
               minus_m = '0;
            end
         endcase
         // upper data bits are junk the register must drop
         upd_data = {$urandom, $urandom};
         cyc_data = {$urandom, $urandom};
         case ($urandom_range(0, 15))
            0:       upd_data[tna_pkg::STEP_W-1:0] = '0;
            1:       upd_data[tna_pkg::STEP_W-1:0] = 10'd1;
            2:       upd_data[tna_pkg::STEP_W-1:0] = 10'd1023;
            default: upd_data[tna_pkg::STEP_W-1:0] = tna_pkg::STEP_W'($urandom_range(2, 160));
         endcase
         cyc_data[tna_pkg::CYC_W-1:0] = tna_pkg::CYC_W'($urandom_range(0, 31));
         configure(plus_m, minus_m, upd_data, cyc_data);
         for (int n = 0; n < PHASE_WORDS; n++)
            send_word(tna_pkg::STATE_W'($urandom_range(0, 255)));
      end

      // Wait out the last searches, then watch for stray response words.
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.owed_q.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl
rtl/tna_pkg.sv
rtl/tna_lane.sv
rtl/tna_match.sv
rtl/threshold_network_attractor_search.sv
bench/testbench.sv
